// ===== rtl/core/mspi_pkg.sv =====
// Shared types, constants and helpers of the MIPS subset interpreter core.
`default_nettype none
package mspi_pkg;

    localparam int unsigned MEM_BYTES = 1048576;
    localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [31:0] TEXT_BASE = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [31:0] GP_INIT   = 32'h1000_8000;
    localparam logic [31:0] SP_INIT   = DATA_BASE + 32'(MEM_BYTES);

    localparam logic [4:0] REG_GP = 5'd28;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;
    localparam logic [4:0] REG_ZERO = 5'd0;

    localparam logic CFG_START_PC    = 1'b0;
    localparam logic CFG_INSTR_COUNT = 1'b1;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TRAP_NEWLINE = 4'h0;
    localparam logic [3:0] TRAP_PRINT   = 4'h1;
    localparam logic [3:0] TRAP_READ    = 4'h5;
    localparam logic [3:0] TRAP_HALT    = 4'ha;

    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_HALTED    = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_BAD_INSTR = 3'd3;
    localparam logic [2:0] ST_BAD_TRAP  = 3'd4;
    localparam logic [2:0] ST_UNALIGNED = 3'd5;
    localparam logic [2:0] ST_DATA_RNG  = 3'd6;
    localparam logic [2:0] ST_FETCH_RNG = 3'd7;

    localparam logic [1:0] PK_NONE    = 2'd0;
    localparam logic [1:0] PK_NEWLINE = 2'd1;
    localparam logic [1:0] PK_INT     = 2'd2;
    localparam logic [1:0] PK_PROMPT  = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MULDIV,
        S_LOAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       wdata;
    } dmem_req_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } md_cmd_t;

    function automatic logic [31:0] rf_reset_value(input logic [4:0] addr);
        logic [31:0] v;
        v = 32'd0;
        if (addr == REG_GP) begin
            v = GP_INIT;
        end else if (addr == REG_SP) begin
            v = SP_INIT;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mspi_regfile.sv =====
// General register file: two registered read ports, one write port, reset presets.
`default_nettype none
module mspi_regfile (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [4:0]       rd_addr_a,
    input  wire logic [4:0]       rd_addr_b,
    output logic [31:0]           rd_data_a,
    output logic [31:0]           rd_data_b,
    input  wire mspi_pkg::rf_wr_t wr
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en && wr.addr != mspi_pkg::REG_ZERO) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.addr != mspi_pkg::REG_ZERO) begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : mspi_pkg::rf_reset_value(rd_addr_a);
        rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : mspi_pkg::rf_reset_value(rd_addr_b);
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mspi_dmem.sv =====
// Word data memory with a clearing sweep after reset.
`default_nettype none
module mspi_dmem (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mspi_pkg::dmem_req_t req,
    output logic [31:0]              rdata,
    output logic                     ready
);

    logic [31:0] mem [mspi_pkg::MEM_WORDS];
    logic [mspi_pkg::MEM_AW-1:0] clr_reg;
    logic                        clearing_reg;
    logic [31:0]                 rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end else if (clearing_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == mspi_pkg::MEM_AW'(mspi_pkg::MEM_WORDS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_reg] <= 32'd0;
        end else if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mspi_muldiv.sv =====
// Iterative signed multiply and divide, one bit a cycle through one 33-bit adder.
`default_nettype none
module mspi_muldiv (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mspi_pkg::md_cmd_t cmd,
    output logic                   done,
    output logic [31:0]            hi,
    output logic [31:0]            lo
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic        div_reg;
    logic        neg_lo_reg;
    logic        neg_hi_reg;
    logic [31:0] mb_reg;
    logic [31:0] acc_reg;
    logic [31:0] q_reg;

    logic        na;
    logic        nb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] opx;
    logic [32:0] opy;
    logic [33:0] sum;
    logic [32:0] shifted;
    logic [63:0] prod;
    logic [63:0] prod_neg;

    assign na = cmd.a[31];
    assign nb = cmd.b[31];
    assign ma = na ? (32'd0 - cmd.a) : cmd.a;
    assign mb = nb ? (32'd0 - cmd.b) : cmd.b;

    // shared adder: add for multiply, subtract for divide
    always_comb begin
        if (div_reg) begin
            opx = {acc_reg, q_reg[31]};
            opy = ~{1'b0, mb_reg};
        end else begin
            opx = {1'b0, acc_reg};
            opy = q_reg[0] ? {1'b0, mb_reg} : 33'd0;
        end
    end
    assign sum     = {1'b0, opx} + {opy[32], opy} + {33'd0, div_reg};
    assign shifted = {acc_reg, q_reg[31]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cnt_reg    <= 5'd0;
            div_reg    <= cmd.is_div;
            neg_lo_reg <= na ^ nb;
            neg_hi_reg <= cmd.is_div ? na : (na ^ nb);
            mb_reg     <= mb;
            acc_reg    <= 32'd0;
            q_reg      <= ma;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (div_reg) begin
                if (!sum[33]) begin
                    acc_reg <= sum[31:0];
                end else begin
                    acc_reg <= shifted[31:0];
                end
                q_reg <= {q_reg[30:0], !sum[33]};
            end else begin
                acc_reg <= sum[32:1];
                q_reg   <= {sum[0], q_reg[31:1]};
            end
        end
    end

    assign prod     = {acc_reg, q_reg};
    assign prod_neg = 64'd0 - prod;

    always_comb begin
        if (div_reg) begin
            lo = neg_lo_reg ? (32'd0 - q_reg) : q_reg;
            hi = neg_hi_reg ? (32'd0 - acc_reg) : acc_reg;
        end else begin
            lo = neg_lo_reg ? prod_neg[31:0] : prod[31:0];
            hi = neg_lo_reg ? prod_neg[63:32] : prod[63:32];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mips_subset_interpreter_core.sv =====
// Top level: sequencer, decode and execute of the MIPS subset interpreter.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_instr, s_read_value
//  m_       out        m_valid / m_ready    m_next_pc, m_status, m_print_kind,
//                                           m_print_value, m_executed_count
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wr_data
//
// An item goes S_IDLE, S_EXEC, S_DONE, with S_LOAD for lw and S_MULDIV for mult and div;
// it goes S_IDLE to S_DONE when halted or out of fetch range; mult and div iterate 32
// times through the shared adder. After reset a sweep clears all MEM_WORDS (262144) words
// of the data memory, with s_ready low. The result sits in an output register; a new item
// is taken while it waits, and the next result holds back until it is taken.
`default_nettype none
module mips_subset_interpreter_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [31:0]        s_instr,
    input  wire logic signed [31:0] s_read_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_next_pc,
    output logic [2:0]              m_status,
    output logic [1:0]              m_print_kind,
    output logic signed [31:0]      m_print_value,
    output logic [31:0]             m_executed_count
);

    mspi_pkg::state_t state_reg, state_next;

    logic [24:0] instr_count_reg;
    logic [31:0] pc_reg;
    logic [31:0] icount_reg;
    logic        halted_reg;
    logic [2:0]  stop_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic [31:0] instr_reg;
    logic [31:0] rdval_reg;
    logic [2:0]  res_status_reg;
    logic [1:0]  res_kind_reg;
    logic [31:0] res_pval_reg;

    logic        m_valid_reg;
    logic [31:0] m_pc_reg;
    logic [2:0]  m_status_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_pval_reg;
    logic [31:0] m_count_reg;

    logic [31:0] rs_data;
    logic [31:0] rt_data;
    logic [31:0] dmem_rdata;
    logic        dmem_ready;
    logic        md_done;
    logic [31:0] md_hi;
    logic [31:0] md_lo;

    mspi_pkg::rf_wr_t    rf_wr;
    mspi_pkg::dmem_req_t dmem_req;
    mspi_pkg::md_cmd_t   md_cmd;

    logic        accept;
    logic        fetch_bad;
    logic        out_free;
    logic [29:0] fetch_idx;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] uimm;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] off;
    logic [31:0] branch_pc;
    logic [31:0] jump_pc;

    logic [2:0]          ex_status;
    logic [1:0]          ex_kind;
    logic [31:0]         ex_pval;
    logic [31:0]         ex_pc;
    mspi_pkg::rf_wr_t    ex_wr;
    logic                ex_md;
    logic                ex_ld;
    logic                ex_st;

    mspi_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr_a (s_instr[25:21]),
        .rd_addr_b (s_instr[20:16]),
        .rd_data_a (rs_data),
        .rd_data_b (rt_data),
        .wr        (rf_wr)
    );

    mspi_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dmem_req),
        .rdata   (dmem_rdata),
        .ready   (dmem_ready)
    );

    mspi_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .done    (md_done),
        .hi      (md_hi),
        .lo      (md_lo)
    );

    assign accept    = (state_reg == mspi_pkg::S_IDLE) && s_valid;
    assign fetch_idx = 30'((pc_reg - mspi_pkg::TEXT_BASE) >> 2);
    assign fetch_bad = fetch_idx >= {5'd0, instr_count_reg};
    assign out_free  = !m_valid_reg || m_ready;

    assign op        = instr_reg[31:26];
    assign fn        = instr_reg[5:0];
    assign rt        = instr_reg[20:16];
    assign rd        = instr_reg[15:11];
    assign sh        = instr_reg[10:6];
    assign uimm      = {16'd0, instr_reg[15:0]};
    assign simm      = {{16{instr_reg[15]}}, instr_reg[15:0]};
    assign ea        = rs_data + simm;
    assign off       = ea - mspi_pkg::DATA_BASE;
    assign branch_pc = pc_reg + {simm[29:0], 2'b00};
    assign jump_pc   = {pc_reg[31:28], instr_reg[25:0], 2'b00};

    // decode and execute
    always_comb begin
        ex_status = mspi_pkg::ST_RUNNING;
        ex_kind   = mspi_pkg::PK_NONE;
        ex_pval   = 32'd0;
        ex_pc     = pc_reg;
        ex_wr     = '0;
        ex_md     = 1'b0;
        ex_ld     = 1'b0;
        ex_st     = 1'b0;
        unique case (op)
            mspi_pkg::OP_SPECIAL: begin
                unique case (fn)
                    mspi_pkg::FN_SLL: ex_wr = '{1'b1, rd, rt_data << sh};
                    mspi_pkg::FN_SRA: ex_wr = '{1'b1, rd, 32'($signed(rt_data) >>> sh)};
                    mspi_pkg::FN_JR: ex_pc = rs_data;
                    mspi_pkg::FN_MFHI: ex_wr = '{1'b1, rd, hi_reg};
                    mspi_pkg::FN_MFLO: ex_wr = '{1'b1, rd, lo_reg};
                    mspi_pkg::FN_MULT: ex_md = 1'b1;
                    mspi_pkg::FN_DIV: begin
                        if (rt_data == 32'd0) begin
                            ex_status = mspi_pkg::ST_DIV_ZERO;
                        end else begin
                            ex_md = 1'b1;
                        end
                    end
                    mspi_pkg::FN_ADDU: ex_wr = '{1'b1, rd, rs_data + rt_data};
                    mspi_pkg::FN_SUBU: ex_wr = '{1'b1, rd, rs_data - rt_data};
                    mspi_pkg::FN_SLT:
                        ex_wr = '{1'b1, rd, {31'd0, $signed(rs_data) < $signed(rt_data)}};
                    default: ex_status = mspi_pkg::ST_BAD_INSTR;
                endcase
            end
            mspi_pkg::OP_J: ex_pc = jump_pc;
            mspi_pkg::OP_JAL: begin
                ex_wr = '{1'b1, mspi_pkg::REG_RA, pc_reg};
                ex_pc = jump_pc;
            end
            mspi_pkg::OP_BEQ: if (rs_data == rt_data) ex_pc = branch_pc;
            mspi_pkg::OP_BNE: if (rs_data != rt_data) ex_pc = branch_pc;
            mspi_pkg::OP_ADDIU: ex_wr = '{1'b1, rt, rs_data + simm};
            mspi_pkg::OP_ANDI: ex_wr = '{1'b1, rt, rs_data & uimm};
            mspi_pkg::OP_LUI: ex_wr = '{1'b1, rt, {instr_reg[15:0], 16'd0}};
            mspi_pkg::OP_TRAP: begin
                unique case (instr_reg[3:0])
                    mspi_pkg::TRAP_NEWLINE: ex_kind = mspi_pkg::PK_NEWLINE;
                    mspi_pkg::TRAP_PRINT: begin
                        ex_kind = mspi_pkg::PK_INT;
                        ex_pval = rs_data;
                    end
                    mspi_pkg::TRAP_READ: begin
                        ex_kind = mspi_pkg::PK_PROMPT;
                        ex_wr   = '{1'b1, rt, rdval_reg};
                    end
                    mspi_pkg::TRAP_HALT: ex_status = mspi_pkg::ST_HALTED;
                    default: ex_status = mspi_pkg::ST_BAD_TRAP;
                endcase
            end
            mspi_pkg::OP_LW, mspi_pkg::OP_SW: begin
                if (ea[1:0] != 2'b00) begin
                    ex_status = mspi_pkg::ST_UNALIGNED;
                end else if (off >= 32'(mspi_pkg::MEM_BYTES)) begin
                    ex_status = mspi_pkg::ST_DATA_RNG;
                end else if (op == mspi_pkg::OP_LW) begin
                    ex_ld = 1'b1;
                end else begin
                    ex_st = 1'b1;
                end
            end
            default: ex_status = mspi_pkg::ST_BAD_INSTR;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mspi_pkg::S_CLEAR: if (dmem_ready) state_next = mspi_pkg::S_IDLE;
            mspi_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (halted_reg || fetch_bad) ? mspi_pkg::S_DONE
                                                            : mspi_pkg::S_EXEC;
                end
            end
            mspi_pkg::S_EXEC: begin
                if (ex_md) begin
                    state_next = mspi_pkg::S_MULDIV;
                end else if (ex_ld) begin
                    state_next = mspi_pkg::S_LOAD;
                end else begin
                    state_next = mspi_pkg::S_DONE;
                end
            end
            mspi_pkg::S_MULDIV: if (md_done) state_next = mspi_pkg::S_DONE;
            mspi_pkg::S_LOAD: state_next = mspi_pkg::S_DONE;
            mspi_pkg::S_DONE: if (out_free) state_next = mspi_pkg::S_IDLE;
            default: state_next = mspi_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready        = (state_reg == mspi_pkg::S_IDLE);
        rf_wr          = '0;
        dmem_req.we    = 1'b0;
        dmem_req.addr  = off[mspi_pkg::MEM_AW+1:2];
        dmem_req.wdata = rt_data;
        md_cmd.start   = 1'b0;
        md_cmd.is_div  = (fn == mspi_pkg::FN_DIV);
        md_cmd.a       = rs_data;
        md_cmd.b       = rt_data;
        unique case (state_reg)
            mspi_pkg::S_EXEC: begin
                rf_wr        = ex_wr;
                dmem_req.we  = ex_st;
                md_cmd.start = ex_md;
            end
            mspi_pkg::S_LOAD: rf_wr = '{1'b1, rt, dmem_rdata};
            default: begin
                rf_wr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mspi_pkg::S_CLEAR;
            instr_count_reg <= 25'd0;
            pc_reg          <= mspi_pkg::TEXT_BASE;
            icount_reg      <= 32'd0;
            halted_reg      <= 1'b0;
            stop_reg        <= mspi_pkg::ST_RUNNING;
            hi_reg          <= 32'd0;
            lo_reg          <= 32'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    mspi_pkg::CFG_START_PC: pc_reg <= cfg_wr_data;
                    mspi_pkg::CFG_INSTR_COUNT: instr_count_reg <= cfg_wr_data[24:0];
                    default: instr_count_reg <= instr_count_reg;
                endcase
            end
            if (accept && !halted_reg) begin
                if (fetch_bad) begin
                    halted_reg <= 1'b1;
                    stop_reg   <= mspi_pkg::ST_FETCH_RNG;
                end else begin
                    icount_reg <= icount_reg + 32'd1;
                    pc_reg     <= pc_reg + 32'd4;
                end
            end
            if (state_reg == mspi_pkg::S_EXEC) begin
                pc_reg <= ex_pc;
                if (ex_status != mspi_pkg::ST_RUNNING) begin
                    halted_reg <= 1'b1;
                    stop_reg   <= ex_status;
                end
            end
            if (state_reg == mspi_pkg::S_MULDIV && md_done) begin
                hi_reg <= md_hi;
                lo_reg <= md_lo;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == mspi_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            instr_reg      <= s_instr;
            rdval_reg      <= s_read_value;
            res_kind_reg   <= mspi_pkg::PK_NONE;
            res_pval_reg   <= 32'd0;
            res_status_reg <= halted_reg ? stop_reg
                            : (fetch_bad ? mspi_pkg::ST_FETCH_RNG : mspi_pkg::ST_RUNNING);
        end
        if (state_reg == mspi_pkg::S_EXEC) begin
            res_status_reg <= ex_status;
            res_kind_reg   <= ex_kind;
            res_pval_reg   <= ex_pval;
        end
        if (state_reg == mspi_pkg::S_DONE && out_free) begin
            m_pc_reg     <= pc_reg;
            m_status_reg <= res_status_reg;
            m_kind_reg   <= res_kind_reg;
            m_pval_reg   <= res_pval_reg;
            m_count_reg  <= icount_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_next_pc        = m_pc_reg;
    assign m_status         = m_status_reg;
    assign m_print_kind     = m_kind_reg;
    assign m_print_value    = m_pval_reg;
    assign m_executed_count = m_count_reg;

endmodule
`default_nettype wire

// ===== dv/tb_mips_subset_interpreter_core.sv =====
// Testbench of the MIPS subset interpreter core: predicted program runs checked item by item.
`timescale 1ns / 100ps
`default_nettype none
module tb_mips_subset_interpreter_core;
    import mspi_pkg::*;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [2:0]  status;
        logic [1:0]  print_kind;
        logic [31:0] print_value;
        logic [31:0] executed_count;
    } outcome_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = CFG_START_PC;
    logic [31:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_instr = '0;
    logic signed [31:0] s_read_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_next_pc;
    logic [2:0]         m_status;
    logic [1:0]         m_print_kind;
    logic signed [31:0] m_print_value;
    logic [31:0]        m_executed_count;

    mips_subset_interpreter_core DUT (.*);

    always #1 aclk = ~aclk;

    // architectural state of the predicted core
    logic [31:0] regs [32];
    logic [31:0] hi_r, lo_r, pc_r, count_r;
    logic [24:0] prog_words;
    logic        stopped;
    logic [2:0]  stop_status;
    logic [31:0] dmem [int unsigned];

    outcome_t pending_q[$];
    int       fail_count = 0;
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;
    int       hold_req = 0;

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] r_word(input logic [4:0] rs, rt, rd, sh, input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs, rt,
                                           input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic bit fetch_ok(input logic [31:0] pc);
        logic [31:0] idx;
        idx = (pc - TEXT_BASE) >> 2;
        return idx < {7'd0, prog_words};
    endfunction

    function automatic outcome_t run_instr(input logic [31:0] ins, input logic [31:0] rv,
                                           input bit commit);
        logic [2:0]  st;
        logic [1:0]  kind;
        logic [31:0] pval, npc, cnt, seq, a, b, simm, uimm, ea, off, rdata;
        logic [31:0] q, r, ma, mb, wdata, new_hi, new_lo;
        logic [4:0]  rs, rt, rd, sh, waddr;
        logic [5:0]  op, fn;
        logic signed [63:0] prod;
        bit          wen, hl_wen, mem_wen;
        outcome_t    res;
        st = ST_RUNNING; kind = PK_NONE; pval = '0; npc = pc_r; cnt = count_r;
        wen = 0; hl_wen = 0; mem_wen = 0; waddr = '0; wdata = '0; new_hi = '0; new_lo = '0;
        off = '0;
        if (stopped) begin
            st = stop_status;
        end else if (!fetch_ok(pc_r)) begin
            st = ST_FETCH_RNG;
        end else begin
            op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
            sh = ins[10:6]; fn = ins[5:0]; uimm = {16'd0, ins[15:0]};
            simm = {{16{ins[15]}}, ins[15:0]};
            a = regs[rs]; b = regs[rt];
            cnt = count_r + 1; seq = pc_r + 4; npc = seq;
            case (op)
                OP_SPECIAL: begin
                    case (fn)
                        FN_SLL: begin wen = 1; waddr = rd; wdata = b << sh; end
                        FN_SRA: begin wen = 1; waddr = rd; wdata = $signed(b) >>> sh; end
                        FN_JR: npc = a;
                        FN_MFHI: begin wen = 1; waddr = rd; wdata = hi_r; end
                        FN_MFLO: begin wen = 1; waddr = rd; wdata = lo_r; end
                        FN_MULT: begin
                            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                            hl_wen = 1; new_hi = prod[63:32]; new_lo = prod[31:0];
                        end
                        FN_DIV: begin
                            if (b == 0) begin
                                st = ST_DIV_ZERO;
                            end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
                                hl_wen = 1; new_lo = 32'h8000_0000; new_hi = '0;
                            end else begin
                                ma = a[31] ? -a : a;
                                mb = b[31] ? -b : b;
                                q = ma / mb; r = ma % mb;
                                hl_wen = 1;
                                new_lo = (a[31] != b[31]) ? -q : q;
                                new_hi = a[31] ? -r : r;
                            end
                        end
                        FN_ADDU: begin wen = 1; waddr = rd; wdata = a + b; end
                        FN_SUBU: begin wen = 1; waddr = rd; wdata = a - b; end
                        FN_SLT: begin
                            wen = 1; waddr = rd; wdata = ($signed(a) < $signed(b)) ? 1 : 0;
                        end
                        default: st = ST_BAD_INSTR;
                    endcase
                end
                OP_J: npc = {seq[31:28], ins[25:0], 2'b00};
                OP_JAL: begin
                    wen = 1; waddr = REG_RA; wdata = seq;
                    npc = {seq[31:28], ins[25:0], 2'b00};
                end
                OP_BEQ: if (a == b) npc = seq + (simm << 2);
                OP_BNE: if (a != b) npc = seq + (simm << 2);
                OP_ADDIU: begin wen = 1; waddr = rt; wdata = a + simm; end
                OP_ANDI: begin wen = 1; waddr = rt; wdata = a & uimm; end
                OP_LUI: begin wen = 1; waddr = rt; wdata = uimm << 16; end
                OP_TRAP: begin
                    case (ins[3:0])
                        TRAP_NEWLINE: kind = PK_NEWLINE;
                        TRAP_PRINT: begin kind = PK_INT; pval = a; end
                        TRAP_READ: begin kind = PK_PROMPT; wen = 1; waddr = rt; wdata = rv; end
                        TRAP_HALT: st = ST_HALTED;
                        default: st = ST_BAD_TRAP;
                    endcase
                end
                OP_LW, OP_SW: begin
                    ea = a + simm;
                    off = ea - DATA_BASE;
                    if (ea[1:0] != 2'b00) begin
                        st = ST_UNALIGNED;
                    end else if (off >= MEM_BYTES) begin
                        st = ST_DATA_RNG;
                    end else if (op == OP_LW) begin
                        rdata = dmem.exists(off >> 2) ? dmem[off >> 2] : '0;
                        wen = 1; waddr = rt; wdata = rdata;
                    end else begin
                        mem_wen = 1; wdata = b;
                    end
                end
                default: st = ST_BAD_INSTR;
            endcase
        end
        if (commit && !stopped) begin
            if (st == ST_RUNNING) begin
                if (wen && waddr != REG_ZERO) regs[waddr] = wdata;
                if (hl_wen) begin hi_r = new_hi; lo_r = new_lo; end
                if (mem_wen) dmem[off >> 2] = wdata;
            end else begin
                stopped = 1; stop_status = st;
            end
            pc_r = npc; count_r = cnt;
        end
        res.next_pc = npc; res.status = st; res.print_kind = kind;
        res.print_value = pval; res.executed_count = cnt;
        return res;
    endfunction

    task automatic send_item(input logic [31:0] ins, input logic [31:0] rv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1; s_instr <= ins; s_read_value <= rv;
        do @(posedge aclk); while (!s_ready);
        pending_q.push_back(run_instr(ins, rv, 1'b1));
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= data;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        if (idx == CFG_START_PC) begin
            pc_r = data;
        end else begin
            prog_words = data[24:0];
        end
    endtask

    task automatic drain;
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_instr;
        logic [4:0]  s, t, d;
        logic [15:0] imm;
        logic [31:0] w;
        s = $urandom_range(0, 31); t = $urandom_range(0, 31); d = $urandom_range(0, 27);
        w = $urandom;
        imm = w[15:0];
        case ($urandom_range(0, 19))
            0: return r_word(s, t, d, w[10:6], FN_SLL);
            1: return r_word(s, t, d, w[10:6], FN_SRA);
            2: return r_word($urandom_range(0, 1) ? REG_RA : s, w[20:16], w[15:11],
                             w[10:6], FN_JR);
            3: return r_word(w[25:21], w[20:16], d, w[10:6], FN_MFHI);
            4: return r_word(w[25:21], w[20:16], d, w[10:6], FN_MFLO);
            5: return r_word(s, t, w[15:11], w[10:6], FN_MULT);
            6: return r_word(s, t, w[15:11], w[10:6], FN_DIV);
            7: return r_word(s, t, d, w[10:6], FN_ADDU);
            8: return r_word(s, t, d, w[10:6], FN_SUBU);
            9: return r_word(s, t, d, w[10:6], FN_SLT);
            10, 11: begin
                w = (TEXT_BASE >> 2) + $urandom_range(0, prog_words - 1);
                return {($urandom_range(0, 1) ? OP_J : OP_JAL), w[25:0]};
            end
            12: begin
                if ($urandom_range(0, 3) != 0) imm = 16'($signed($urandom_range(0, 16)) - 8);
                return i_word($urandom_range(0, 1) ? OP_BEQ : OP_BNE, s, t, imm);
            end
            13: return i_word(OP_ADDIU, s, d, imm);
            14: return i_word(OP_ANDI, s, d, imm);
            15: return i_word(OP_LUI, s, d, imm);
            16: begin
                case ($urandom_range(0, 2))
                    0: w[3:0] = TRAP_NEWLINE;
                    1: w[3:0] = TRAP_PRINT;
                    default: w[3:0] = TRAP_READ;
                endcase
                return {OP_TRAP, s, d, w[15:0]};
            end
            17, 18: begin
                if ($urandom_range(0, 1)) imm = 16'($urandom_range(0, 15) * 4);
                else imm = imm & 16'hfffc;
                if ($urandom_range(0, 1)) begin
                    s = REG_SP; imm[15] = 1'b1;
                    if (imm == 16'h8000 && $urandom_range(0, 1)) imm = 16'hfffc;
                end else begin
                    s = REG_GP;
                end
                if (imm == 16'h8000 && s == REG_SP) imm = 16'hfff0;
                return i_word($urandom_range(0, 1) ? OP_LW : OP_SW, s,
                              $urandom_range(0, 1) ? d : t, imm);
            end
            default: return w;
        endcase
    endfunction

    task automatic send_legal;
        logic [31:0] ins, rv;
        outcome_t    probe;
        rv = $urandom;
        do begin
            ins = random_instr();
            probe = run_instr(ins, rv, 1'b0);
        end while (probe.status != ST_RUNNING || !fetch_ok(probe.next_pc));
        send_item(ins, rv);
    endtask

    task automatic send_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
            send_legal();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed;
        logic [31:0] ret;
        send_item(i_word(OP_LUI, REG_ZERO, 5'd8, 16'h8000), '0);
        send_item(i_word(OP_ADDIU, REG_ZERO, 5'd9, 16'hffff), '0);
        send_item(r_word(5'd8, 5'd9, 5'd0, 5'd0, FN_DIV), '0);
        send_item(r_word(5'd0, 5'd0, 5'd10, 5'd0, FN_MFLO), '0);
        send_item(r_word(5'd0, 5'd0, 5'd11, 5'd0, FN_MFHI), '0);
        send_item(r_word(5'd8, 5'd8, 5'd0, 5'd0, FN_MULT), '0);
        send_item(r_word(5'd0, 5'd0, 5'd12, 5'd0, FN_MFHI), '0);
        send_item(i_word(OP_ADDIU, REG_ZERO, 5'd14, 16'hfff9), '0);
        send_item(i_word(OP_ADDIU, REG_ZERO, 5'd15, 16'h0002), '0);
        send_item(r_word(5'd14, 5'd15, 5'd0, 5'd0, FN_DIV), '0);
        send_item(r_word(5'd0, 5'd0, 5'd16, 5'd0, FN_MFHI), '0);
        send_item(r_word(5'd0, 5'd8, 5'd18, 5'd31, FN_SRA), '0);
        send_item(r_word(5'd0, 5'd9, 5'd19, 5'd31, FN_SLL), '0);
        send_item(r_word(5'd8, 5'd9, 5'd20, 5'd0, FN_SLT), '0);
        send_item(r_word(5'd8, 5'd9, 5'd0, 5'd0, FN_SUBU), '0);
        send_item({OP_TRAP, 5'd8, 5'd0, 12'd0, TRAP_PRINT}, '0);
        send_item({OP_TRAP, 5'd0, 5'd0, 12'd0, TRAP_NEWLINE}, '0);
        send_item({OP_TRAP, 5'd0, 5'd21, 12'd0, TRAP_READ}, 32'h8000_0000);
        send_item({OP_TRAP, 5'd0, 5'd22, 12'd0, TRAP_READ}, 32'h7fff_ffff);
        send_item(i_word(OP_SW, REG_SP, 5'd8, 16'hfffc), '0);
        send_item(i_word(OP_LW, REG_SP, 5'd23, 16'hfffc), '0);
        send_item(i_word(OP_SW, REG_GP, 5'd22, 16'h7ffc), '0);
        send_item(i_word(OP_LW, REG_GP, 5'd24, 16'h7ffc), '0);
        ret = (pc_r + 8) >> 2;
        send_item({OP_JAL, ret[25:0]}, '0);
        send_item(r_word(REG_RA, 5'd0, 5'd0, 5'd0, FN_JR), '0);
        send_item(i_word(OP_BEQ, REG_ZERO, REG_ZERO, 16'h0001), '0);
        send_item(32'h0000_0000, 32'hffff_ffff);
    endtask

    task automatic test_random_run;
        send_random(300);
    endtask

    task automatic test_backpressure;
        hold_req = 300;
        no_idle = 1'b1;
        repeat (40) send_legal();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause;
        send_random(30);
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        send_random(30);
    endtask

    task automatic test_small_program;
        int k;
        drain();
        k = $urandom_range(0, 31);
        write_reg(CFG_INSTR_COUNT, 32'(40 + k));
        write_reg(CFG_START_PC, TEXT_BASE + 32'(4 * k));
        send_random(150);
        drain();
        write_reg(CFG_START_PC, TEXT_BASE);
        write_reg(CFG_INSTR_COUNT, 32'd1);
        send_random(20);
        drain();
        write_reg(CFG_INSTR_COUNT, 32'h0100_0000);
        send_random(100);
    endtask

    task automatic test_stop_and_halted;
        logic [31:0] ins;
        int          sel;
        ins = 32'hffff_ffff;
        sel = $urandom_range(0, 6);
        case (sel)
            0: ins = r_word(5'd8, REG_ZERO, 5'd0, 5'd0, FN_DIV);
            1: ins = 32'hffff_ffff;
            2: ins = {OP_TRAP, 5'd0, 5'd0, 12'd0, 4'h3};
            3: ins = i_word(OP_LW, REG_GP, 5'd8, 16'h0001);
            4: ins = i_word(OP_SW, REG_ZERO, 5'd8, 16'h0000);
            5: begin
                drain();
                write_reg(CFG_INSTR_COUNT, 32'd0);
            end
            default: ins = {OP_TRAP, 5'd0, 5'd0, 12'd0, TRAP_HALT};
        endcase
        send_item(ins, $urandom);
        repeat (8) send_item($urandom, $urandom);
        send_item(32'hffff_ffff, 32'hffff_ffff);
        drain();
        write_reg(CFG_START_PC, 32'h0000_0000);
        write_reg(CFG_INSTR_COUNT, 32'd0);
        send_item($urandom, $urandom);
        drain();
        write_reg(CFG_START_PC, 32'hffff_ffff);
        write_reg(CFG_INSTR_COUNT, 32'h0100_0000);
        repeat (4) send_item($urandom, $urandom);
    endtask

    // result checker with its own stall per item
    initial begin : result_check
        outcome_t want;
        int       stall;
        @(posedge aresetn);
        forever begin
            if (hold_req != 0) begin
                stall = hold_req; hold_req = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_q.size() == 0) begin
                fail_count++;
                if (mismatch_count < 10) $display("unexpected item pc=%h", m_next_pc);
                mismatch_count++;
            end else begin
                want = pending_q.pop_front();
                if (want.next_pc !== m_next_pc || want.status !== m_status ||
                    want.print_kind !== m_print_kind || want.print_value !== m_print_value ||
                    want.executed_count !== m_executed_count) begin
                    fail_count++;
                    if (mismatch_count < 10) begin
                        $display("mismatch exp pc=%h st=%0d pk=%0d pv=%h n=%0d",
                                 want.next_pc, want.status, want.print_kind,
                                 want.print_value, want.executed_count);
                        $display("         got pc=%h st=%0d pk=%0d pv=%h n=%0d",
                                 m_next_pc, m_status, m_print_kind,
                                 m_print_value, m_executed_count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 32; i++) regs[i] = '0;
        regs[REG_GP] = GP_INIT;
        regs[REG_SP] = SP_INIT;
        hi_r = '0; lo_r = '0; count_r = '0; pc_r = TEXT_BASE;
        prog_words = '0; stopped = 0; stop_status = ST_RUNNING;
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        write_reg(CFG_START_PC, TEXT_BASE);
        write_reg(CFG_INSTR_COUNT, 32'h0100_0000);
        test_directed();
        test_random_run();
        test_backpressure();
        test_drain_pause();
        test_small_program();
        test_stop_and_halted();
        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
